// ===== hdl/rrts_pkg.sv =====
package rrts_pkg;

  localparam int MAX_THREADS = 16;
  localparam int ID_W        = $clog2(MAX_THREADS);
  localparam int QDEPTH      = MAX_THREADS - 1;
  localparam int QI_W        = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int QF_W        = $clog2(QDEPTH + 1);
  localparam int CNT_W       = $clog2(MAX_THREADS + 1);

  // request kinds
  localparam logic [1:0] K_SPAWN = 2'd0;
  localparam logic [1:0] K_YIELD = 2'd1;
  localparam logic [1:0] K_SCHED = 2'd2;
  localparam logic [1:0] K_EXIT  = 2'd3;

  // response status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_BADTARGET = 3'd2;
  localparam logic [2:0] ST_NOSWITCH  = 3'd3;
  localparam logic [2:0] ST_HALTED    = 3'd4;

  typedef struct packed {
    logic [1:0] kind;
    logic [3:0] target_id;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] returned_id;
    logic [3:0] running_id;
  } rsp_t;

endpackage

// ===== hdl/round_robin_thread_scheduler_top.sv =====
// Round-robin thread scheduler. Each request item (spawn, yield to target,
// schedule next, exit running thread) gives one response item carrying a
// status, the returned thread id and the thread running afterwards. Requests
// are handled one at a time by a small sequencer that touches one slot or one
// ready-queue entry per cycle: spawn scans slots from the next-fit pointer;
// yield searches the queue for the target and then closes the gap behind it;
// schedule and exit pop the head and close the gap. Rejected requests go
// straight to the response state. A finished response sits in an output
// register, so the next request is taken while it waits. Once no thread is
// active every request answers halted until reset.
module round_robin_thread_scheduler_top
  import rrts_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_ready,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SPAWN,
    S_YIELD,
    S_SCHED,
    S_SHIFT,
    S_RESP
  } state_t;

  state_t                   state;
  logic [MAX_THREADS-1:0]   slot_valid;
  logic [ID_W-1:0]          queue [QDEPTH];
  logic [QF_W-1:0]          fill;
  logic [ID_W-1:0]          running;
  logic [ID_W-1:0]          last_assigned;
  logic [CNT_W-1:0]         active;
  logic [ID_W-1:0]          target;
  logic [ID_W-1:0]          scan_slot;
  logic [CNT_W-1:0]         scan_cnt;
  logic [QF_W-1:0]          qidx;
  logic [ID_W-1:0]          app_id;
  logic                     app_en;
  logic [2:0]               res_status;
  logic [ID_W-1:0]          res_ret;

  logic [QI_W-1:0]          rd_addr;
  logic [ID_W-1:0]          q_rd;
  logic [ID_W-1:0]          spawn_start;
  logic [ID_W-1:0]          req_tgt;
  logic                     tgt_range_bad;
  logic [CNT_W-1:0]         active_dec;

  assign req_ready = (state == S_IDLE);

  // single queue read port: gap closing reads one entry ahead
  assign rd_addr = (state == S_SHIFT) ? QI_W'(qidx + 1'b1) : qidx[QI_W-1:0];
  assign q_rd    = queue[rd_addr];

  assign spawn_start   = (32'(last_assigned) >= 32'(MAX_THREADS - 1)) ? '0
                         : ID_W'(last_assigned + 1'b1);
  assign req_tgt       = ID_W'(req.target_id);
  assign tgt_range_bad = 32'(req.target_id) >= 32'(MAX_THREADS);
  assign active_dec    = slot_valid[running] ? CNT_W'(active - 1'b1) : active;

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      slot_valid    <= MAX_THREADS'(1);
      fill          <= '0;
      running       <= '0;
      last_assigned <= '0;
      active        <= CNT_W'(1);
      rsp_valid     <= 1'b0;
    end else begin
      // S_RESP reloads the output register itself
      if (rsp_valid && rsp_ready && state != S_RESP) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (req_valid) begin
            target <= req_tgt;
            qidx   <= '0;
            if (active == '0) begin
              res_status <= ST_HALTED;
              res_ret    <= '0;
              state      <= S_RESP;
            end else begin
              case (req.kind)
                K_SPAWN: begin
                  if (32'(active) >= 32'(MAX_THREADS)) begin
                    res_status <= ST_FULL;
                    res_ret    <= '0;
                    state      <= S_RESP;
                  end else begin
                    scan_slot <= spawn_start;
                    scan_cnt  <= '0;
                    state     <= S_SPAWN;
                  end
                end
                K_YIELD: begin
                  if (tgt_range_bad || !slot_valid[req_tgt]) begin
                    res_status <= ST_BADTARGET;
                    res_ret    <= '0;
                    state      <= S_RESP;
                  end else if (req_tgt == running) begin
                    res_status <= ST_NOSWITCH;
                    res_ret    <= running;
                    state      <= S_RESP;
                  end else begin
                    state <= S_YIELD;
                  end
                end
                K_SCHED: begin
                  res_ret <= running;
                  state   <= S_SCHED;
                end
                K_EXIT: begin
                  res_ret <= running;
                  slot_valid[running] <= 1'b0;
                  active <= active_dec;
                  if (active_dec == '0) begin
                    res_status <= ST_HALTED;
                    state      <= S_RESP;
                  end else begin
                    state <= S_SCHED;
                  end
                end
                default: state <= S_IDLE;
              endcase
            end
          end
        end

        S_SPAWN: begin
          if (!slot_valid[scan_slot]) begin
            slot_valid[scan_slot] <= 1'b1;
            last_assigned <= scan_slot;
            active        <= CNT_W'(active + 1'b1);
            if (32'(fill) < 32'(QDEPTH)) begin
              queue[fill[QI_W-1:0]] <= scan_slot;
              fill <= QF_W'(fill + 1'b1);
            end
            res_status <= ST_OK;
            res_ret    <= scan_slot;
            state      <= S_RESP;
          end else if (32'(scan_cnt) >= 32'(MAX_THREADS - 1)) begin
            res_status <= ST_FULL;
            res_ret    <= '0;
            state      <= S_RESP;
          end else begin
            scan_slot <= (32'(scan_slot) >= 32'(MAX_THREADS - 1)) ? '0
                         : ID_W'(scan_slot + 1'b1);
            scan_cnt  <= CNT_W'(scan_cnt + 1'b1);
          end
        end

        S_YIELD: begin
          if (qidx == fill) begin
            res_status <= ST_NOSWITCH;
            res_ret    <= running;
            state      <= S_RESP;
          end else if (q_rd == target) begin
            res_status <= ST_OK;
            res_ret    <= running;
            app_id     <= running;
            app_en     <= 1'b1;
            running    <= target;
            state      <= S_SHIFT;
          end else begin
            qidx <= QF_W'(qidx + 1'b1);
          end
        end

        S_SCHED: begin
          // qidx is zero here, so q_rd is the queue head
          if (fill == '0 || !slot_valid[q_rd]) begin
            res_status <= ST_NOSWITCH;
            state      <= S_RESP;
          end else begin
            res_status <= ST_OK;
            app_id     <= running;
            app_en     <= slot_valid[running];
            running    <= q_rd;
            state      <= S_SHIFT;
          end
        end

        S_SHIFT: begin
          if (32'(qidx) + 32'd1 < 32'(fill)) begin
            queue[qidx[QI_W-1:0]] <= q_rd;
            qidx <= QF_W'(qidx + 1'b1);
          end else begin
            // removal frees one entry, so the append always fits
            if (app_en) begin
              queue[QI_W'(fill - 1'b1)] <= app_id;
            end else begin
              fill <= QF_W'(fill - 1'b1);
            end
            state <= S_RESP;
          end
        end

        S_RESP: begin
          if (!rsp_valid || rsp_ready) begin
            rsp_valid       <= 1'b1;
            rsp.status      <= res_status;
            rsp.returned_id <= 4'(res_ret);
            rsp.running_id  <= 4'(running);
            state           <= S_IDLE;
          end
        end

        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
